// ===== hdl/tracked_bump_allocator_defines.svh =====
// Assertion macros for the allocator checker.
`ifndef TRACKED_BUMP_ALLOCATOR_DEFINES_SVH
`define TRACKED_BUMP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TBA_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TBA_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hdl/tba_pkg.sv =====
// Constants, codes and types of the tracked bump allocator.
package tba_pkg;

   localparam int unsigned POOL_BYTES  = 1048576;
   localparam int unsigned ENTRY_BYTES = 24;
   localparam int unsigned MAX_ENTRIES = 256;

   localparam int unsigned SLOT_W = $clog2(MAX_ENTRIES);
   localparam int unsigned SIZE_W = 21;
   localparam int unsigned TGT_W  = 20;
   localparam int unsigned OFFS_W = 21;
   localparam int unsigned SUM_W  = 22;
   localparam int unsigned RES_W  = SUM_W + 1;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_EXHAUSTED = 2'd1;
   localparam logic [1:0] STS_UNTRACKED = 2'd2;
   localparam logic [1:0] STS_UNKNOWN   = 2'd3;

   typedef struct packed {
      logic [OFFS_W-1:0] addr;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic             sub;
      logic [SUM_W-1:0] a;
      logic [SUM_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } probe_type;

endpackage

// ===== hdl/tracked_bump_allocator.sv =====
// Tracked bump allocator top level: sequencer, pointer, total and valid bits.
//
//   channel  direction  handshake              words
//   req_     in         start high, busy low   op, size, target, null flag
//   rsp_     out        rsp_strobe, one cycle  status, grant, address, total
//
// Clear, null free, undefined op: S_SIMPLE. Allocate: size add in S_ADD1
// (exhausted ends here), entry-cost add in S_ADD2 (no room for the entry ends
// here), lowest free slot search in S_FIND (table full ends here), S_TOTAL.
// Free: S_SCAN reads every slot, one slot per cycle, then S_DRAIN and S_FREE.
// busy drops in the strobe cycle; the receiver cannot stall, so results never wait.
// Synchronous reset empties the table valid bits at once; no clearing pass.
module tracked_bump_allocator
   import tba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_op,
   input  logic [SIZE_W-1:0] req_block_size,
   input  logic [TGT_W-1:0]  req_target_address,
   input  logic              req_target_is_null,
   output logic              rsp_strobe,
   output logic [1:0]        rsp_status,
   output logic              rsp_granted,
   output logic [OFFS_W-1:0] rsp_granted_address,
   output logic [OFFS_W-1:0] rsp_total_bytes
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SIMPLE = 4'd1;
   localparam logic [3:0] S_ADD1   = 4'd2;
   localparam logic [3:0] S_ADD2   = 4'd3;
   localparam logic [3:0] S_FIND   = 4'd4;
   localparam logic [3:0] S_TOTAL  = 4'd5;
   localparam logic [3:0] S_SCAN   = 4'd6;
   localparam logic [3:0] S_DRAIN  = 4'd7;
   localparam logic [3:0] S_FREE   = 4'd8;

   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(MAX_ENTRIES - 1);
   localparam logic [RES_W-1:0]  POOL_LIMIT = RES_W'(POOL_BYTES);
   localparam logic [SUM_W-1:0]  ENTRY_COST = SUM_W'(ENTRY_BYTES);

   logic [3:0]             state_ff, state_in;
   logic [OFFS_W-1:0]      next_offset_ff, next_offset_in;
   logic [OFFS_W-1:0]      live_total_ff, live_total_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [SLOT_W-1:0]      scan_slot_ff, scan_slot_in;
   logic                   hit_found_ff, hit_found_in;
   logic [SLOT_W-1:0]      hit_slot_ff, hit_slot_in;
   logic [SIZE_W-1:0]      best_size_ff, best_size_in;
   logic                   chk_on_ff, chk_on_in;
   logic [SLOT_W-1:0]      chk_slot_ff, chk_slot_in;
   logic                   chk_valid_ff, chk_valid_in;
   logic [SIZE_W-1:0]      size_ff, size_in;
   logic [TGT_W-1:0]       target_ff, target_in;
   logic [OFFS_W-1:0]      addr_ff, addr_in;
   logic                   strobe_ff, strobe_in;
   logic [1:0]             status_ff, status_in;
   logic                   granted_ff, granted_in;
   logic [OFFS_W-1:0]      gaddr_ff, gaddr_in;

   alu_req_type      alu_req;
   logic [RES_W-1:0] alu_res;
   logic             ram_we;
   entry_type        ram_wdata;
   entry_type        ram_rdata;
   probe_type        probe;
   logic             take;

   tba_alu u_alu (
      .req (alu_req),
      .res (alu_res)
   );

   assign ram_wdata.addr = addr_ff;
   assign ram_wdata.size = size_ff;

   tba_entry_ram u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (scan_slot_ff),
      .wdata (ram_wdata),
      .raddr (scan_slot_ff),
      .rdata (ram_rdata)
   );

   assign probe.valid = chk_on_ff && chk_valid_ff;
   assign probe.entry = ram_rdata;

   tba_match u_match (
      .probe     (probe),
      .target    (target_ff),
      .hit_found (hit_found_ff),
      .best_size (best_size_ff),
      .take      (take)
   );

   always_comb begin
      state_in       = state_ff;
      next_offset_in = next_offset_ff;
      live_total_in  = live_total_ff;
      valid_in       = valid_ff;
      scan_slot_in   = scan_slot_ff;
      hit_found_in   = hit_found_ff;
      hit_slot_in    = hit_slot_ff;
      best_size_in   = best_size_ff;
      chk_on_in      = 1'b0;
      chk_slot_in    = scan_slot_ff;
      chk_valid_in   = valid_ff[scan_slot_ff];
      size_in        = size_ff;
      target_in      = target_ff;
      addr_in        = addr_ff;
      strobe_in      = 1'b0;
      status_in      = status_ff;
      granted_in     = granted_ff;
      gaddr_in       = gaddr_ff;
      ram_we         = 1'b0;
      alu_req.sub    = 1'b0;
      alu_req.a      = SUM_W'(next_offset_ff);
      alu_req.b      = SUM_W'(size_ff);

      // compare stage works on the registered table read, in the cycle after the read
      if (take) begin
         hit_found_in = 1'b1;
         hit_slot_in  = chk_slot_ff;
         best_size_in = ram_rdata.size;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               size_in   = req_block_size;
               target_in = req_target_address;
               case (req_op)
                  OP_ALLOC: begin
                     state_in = S_ADD1;
                  end
                  OP_FREE: begin
                     if (req_target_is_null) begin
                        state_in = S_SIMPLE;
                     end else begin
                        scan_slot_in = '0;
                        hit_found_in = 1'b0;
                        state_in     = S_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     next_offset_in = '0;
                     live_total_in  = '0;
                     valid_in       = '0;
                     state_in       = S_SIMPLE;
                  end
                  default: begin
                     state_in = S_SIMPLE;
                  end
               endcase
            end
         end
         S_SIMPLE: begin
            strobe_in  = 1'b1;
            status_in  = STS_OK;
            granted_in = 1'b0;
            gaddr_in   = '0;
            state_in   = S_IDLE;
         end
         S_ADD1: begin
            if (alu_res > POOL_LIMIT) begin
               strobe_in  = 1'b1;
               status_in  = STS_EXHAUSTED;
               granted_in = 1'b0;
               gaddr_in   = '0;
               state_in   = S_IDLE;
            end else begin
               next_offset_in = alu_res[OFFS_W-1:0];
               addr_in        = next_offset_ff;
               state_in       = S_ADD2;
            end
         end
         S_ADD2: begin
            alu_req.b = ENTRY_COST;
            if (alu_res > POOL_LIMIT) begin
               strobe_in  = 1'b1;
               status_in  = STS_UNTRACKED;
               granted_in = 1'b1;
               gaddr_in   = addr_ff;
               state_in   = S_IDLE;
            end else begin
               scan_slot_in = '0;
               state_in     = S_FIND;
            end
         end
         S_FIND: begin
            alu_req.b = ENTRY_COST;
            if (!valid_ff[scan_slot_ff]) begin
               ram_we                 = 1'b1;
               valid_in[scan_slot_ff] = 1'b1;
               next_offset_in         = alu_res[OFFS_W-1:0];
               state_in               = S_TOTAL;
            end else if (scan_slot_ff == LAST_SLOT) begin
               // table full: keep the grant, skip tracking
               strobe_in  = 1'b1;
               status_in  = STS_UNTRACKED;
               granted_in = 1'b1;
               gaddr_in   = addr_ff;
               state_in   = S_IDLE;
            end else begin
               scan_slot_in = scan_slot_ff + 1'b1;
            end
         end
         S_TOTAL: begin
            alu_req.a     = SUM_W'(live_total_ff);
            live_total_in = alu_res[OFFS_W-1:0];
            strobe_in     = 1'b1;
            status_in     = STS_OK;
            granted_in    = 1'b1;
            gaddr_in      = addr_ff;
            state_in      = S_IDLE;
         end
         S_SCAN: begin
            chk_on_in = 1'b1;
            if (scan_slot_ff == LAST_SLOT) begin
               state_in = S_DRAIN;
            end else begin
               scan_slot_in = scan_slot_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_FREE;
         end
         S_FREE: begin
            alu_req.sub = 1'b1;
            alu_req.a   = SUM_W'(live_total_ff);
            alu_req.b   = SUM_W'(best_size_ff);
            strobe_in   = 1'b1;
            granted_in  = 1'b0;
            gaddr_in    = '0;
            state_in    = S_IDLE;
            if (!hit_found_ff) begin
               status_in = STS_UNKNOWN;
            end else begin
               status_in             = STS_OK;
               valid_in[hit_slot_ff] = 1'b0;
               // floor the total at zero on borrow
               live_total_in = alu_res[RES_W-1] ? '0 : alu_res[OFFS_W-1:0];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         next_offset_ff <= '0;
         live_total_ff  <= '0;
         valid_ff       <= '0;
         chk_on_ff      <= 1'b0;
         hit_found_ff   <= 1'b0;
         strobe_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         next_offset_ff <= next_offset_in;
         live_total_ff  <= live_total_in;
         valid_ff       <= valid_in;
         chk_on_ff      <= chk_on_in;
         hit_found_ff   <= hit_found_in;
         strobe_ff      <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_slot_ff <= scan_slot_in;
      hit_slot_ff  <= hit_slot_in;
      best_size_ff <= best_size_in;
      chk_slot_ff  <= chk_slot_in;
      chk_valid_ff <= chk_valid_in;
      size_ff      <= size_in;
      target_ff    <= target_in;
      addr_ff      <= addr_in;
      status_ff    <= status_in;
      granted_ff   <= granted_in;
      gaddr_ff     <= gaddr_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_strobe          = strobe_ff;
   assign rsp_status          = status_ff;
   assign rsp_granted         = granted_ff;
   assign rsp_granted_address = gaddr_ff;
   assign rsp_total_bytes     = live_total_ff;

endmodule

// ===== hdl/tba_alu.sv =====
// Shared add/subtract unit for pointer, limit and total arithmetic.
module tba_alu
   import tba_pkg::*;
(
   input  alu_req_type      req,
   output logic [RES_W-1:0] res
);

   always_comb begin
      if (req.sub) begin
         res = {1'b0, req.a} - {1'b0, req.b};
      end else begin
         res = {1'b0, req.a} + {1'b0, req.b};
      end
   end

endmodule

// ===== hdl/tba_match.sv =====
// Entry compare unit: picks the largest live entry at the target address.
module tba_match
   import tba_pkg::*;
(
   input  probe_type         probe,
   input  logic [TGT_W-1:0]  target,
   input  logic              hit_found,
   input  logic [SIZE_W-1:0] best_size,
   output logic              take
);

   logic addr_eq;

   // full-width compare: an entry at the pool end never matches
   assign addr_eq = (probe.entry.addr == {1'b0, target});
   assign take    = probe.valid && addr_eq &&
                    (!hit_found || (probe.entry.size > best_size));

endmodule

// ===== hdl/tba_entry_ram.sv =====
// Tracking table storage: address and size per slot, registered read.
module tba_entry_ram
   import tba_pkg::*;
(
   input  logic              clock,
   input  logic              we,
   input  logic [SLOT_W-1:0] waddr,
   input  entry_type         wdata,
   input  logic [SLOT_W-1:0] raddr,
   output entry_type         rdata
);

   entry_type mem [MAX_ENTRIES];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== hdl/tba_checker.sv =====
// Port-level checker for the tracked bump allocator, bound to the top level.
`include "tracked_bump_allocator_defines.svh"

module tba_checker
   import tba_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [1:0]        req_op,
   input logic [SIZE_W-1:0] req_block_size,
   input logic [TGT_W-1:0]  req_target_address,
   input logic              req_target_is_null,
   input logic              rsp_strobe,
   input logic [1:0]        rsp_status,
   input logic              rsp_granted,
   input logic [OFFS_W-1:0] rsp_granted_address,
   input logic [OFFS_W-1:0] rsp_total_bytes
);

   `TBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")

   `TBA_ASSERT_SAME(a_strobe_after_work, rsp_strobe, !busy && $past(busy), "result word without a busy period")

   `TBA_ASSERT_SAME(a_grant_status, rsp_strobe && rsp_granted, (rsp_status == STS_OK) || (rsp_status == STS_UNTRACKED), "grant with a failing status")

   `TBA_ASSERT_SAME(a_no_grant_addr, rsp_strobe && !rsp_granted, rsp_granted_address == '0, "address shown without a grant")

endmodule

bind tracked_bump_allocator tba_checker u_tba_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the tracked bump allocator.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tba_pkg::*;

   localparam logic [1:0] OP_UNDEFINED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 800000;
   localparam int unsigned RANDOM_WORDS = 450;
   localparam int unsigned SETTLE_CYCLES = MAX_ENTRIES + 40;

   class pool_ledger;
      typedef struct {
         logic [1:0]        status;
         logic              granted;
         logic [OFFS_W-1:0] address;
         logic [OFFS_W-1:0] total;
      } rsp_word_type;

      logic [OFFS_W-1:0] bump_offset;
      logic [OFFS_W-1:0] live_total;
      logic [OFFS_W-1:0] slot_addr [MAX_ENTRIES];
      logic [SIZE_W-1:0] slot_size [MAX_ENTRIES];
      bit                slot_live [MAX_ENTRIES];
      rsp_word_type      due_words [$];
      int                errors;

      function new();
         errors = 0;
         wipe();
      endfunction

      function void wipe();
         bump_offset = '0;
         live_total  = '0;
         foreach (slot_live[i]) begin
            slot_live[i] = 1'b0;
            slot_addr[i] = '0;
            slot_size[i] = '0;
         end
      endfunction

      // Advance the allocator state by one accepted word and queue its response.
      function void note_request(logic [1:0] op, logic [SIZE_W-1:0] size,
                                 logic [TGT_W-1:0] target, logic is_null);
         rsp_word_type      w;
         logic [SUM_W-1:0]  reach;
         int                slot;
         w.status  = STS_OK;
         w.granted = 1'b0;
         w.address = '0;
         case (op)
            OP_ALLOC: begin
               reach = bump_offset + size;
               if (reach > POOL_BYTES) begin
                  w.status = STS_EXHAUSTED;
               end else begin
                  w.granted   = 1'b1;
                  w.address   = bump_offset;
                  bump_offset = reach[OFFS_W-1:0];
                  slot = -1;
                  for (int i = 0; i < MAX_ENTRIES; i++) begin
                     if (!slot_live[i]) begin
                        slot = i;
                        break;
                     end
                  end
                  reach = bump_offset + ENTRY_BYTES;
                  if (slot < 0 || reach > POOL_BYTES) begin
                     w.status = STS_UNTRACKED;
                  end else begin
                     bump_offset     = reach[OFFS_W-1:0];
                     slot_live[slot] = 1'b1;
                     slot_addr[slot] = w.address;
                     slot_size[slot] = size;
                     live_total      = live_total + size;
                  end
               end
            end
            OP_FREE: begin
               if (!is_null) begin
                  slot = -1;
                  // take the largest live entry at that address, lowest slot on ties
                  for (int i = 0; i < MAX_ENTRIES; i++) begin
                     if (slot_live[i] && slot_addr[i] == {1'b0, target}) begin
                        if (slot < 0 || slot_size[i] > slot_size[slot])
                           slot = i;
                     end
                  end
                  if (slot < 0) begin
                     w.status = STS_UNKNOWN;
                  end else begin
                     slot_live[slot] = 1'b0;
                     live_total = (live_total >= slot_size[slot]) ?
                                  live_total - slot_size[slot] : '0;
                  end
               end
            end
            OP_CLEAR: wipe();
            default: ;
         endcase
         w.total = live_total;
         due_words.push_back(w);
      endfunction

      function bit pick_live(output logic [TGT_W-1:0] target);
         int idx [$];
         target = '0;
         foreach (slot_live[i])
            if (slot_live[i]) idx.push_back(i);
         if (idx.size() == 0) return 1'b0;
         target = slot_addr[idx[$urandom_range(0, idx.size() - 1)]][TGT_W-1:0];
         return 1'b1;
      endfunction

      function int pending();
         return due_words.size();
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 40) $display("mismatch %0t: %s", $realtime, msg);
      endtask

      task check_word(logic [1:0] status, logic granted,
                      logic [OFFS_W-1:0] address, logic [OFFS_W-1:0] total);
         rsp_word_type w;
         if (due_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word status=%0d", status));
            return;
         end
         w = due_words.pop_front();
         if (status !== w.status)
            report_mismatch($sformatf("status %0d, want %0d", status, w.status));
         if (granted !== w.granted)
            report_mismatch($sformatf("granted %0b, want %0b", granted, w.granted));
         if (address !== w.address)
            report_mismatch($sformatf("address %0h, want %0h", address, w.address));
         if (total !== w.total)
            report_mismatch($sformatf("total %0h, want %0h", total, w.total));
      endtask

      task check_drained();
         if (due_words.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", due_words.size()));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_op;
   logic [SIZE_W-1:0] req_block_size;
   logic [TGT_W-1:0]  req_target_address;
   logic              req_target_is_null;
   logic              rsp_strobe;
   logic [1:0]        rsp_status;
   logic              rsp_granted;
   logic [OFFS_W-1:0] rsp_granted_address;
   logic [OFFS_W-1:0] rsp_total_bytes;

   pool_ledger  ledger = new();
   int unsigned cycles = 0;
   int unsigned words_sent = 0;
   bit          quiet = 1'b0;

   tracked_bump_allocator uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_block_size      (req_block_size),
      .req_target_address  (req_target_address),
      .req_target_is_null  (req_target_is_null),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_granted         (rsp_granted),
      .rsp_granted_address (rsp_granted_address),
      .rsp_total_bytes     (rsp_total_bytes)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         ledger.check_word(rsp_status, rsp_granted, rsp_granted_address, rsp_total_bytes);
   end

   // Hold one word on the request ports until the block takes it.
   task automatic send_word(logic [1:0] op, logic [SIZE_W-1:0] size,
                            logic [TGT_W-1:0] target, logic is_null);
      int gap;
      gap = quiet ? 0 : int'($urandom_range(0, 17));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start              <= 1'b1;
      req_op             <= op;
      req_block_size     <= size;
      req_target_address <= target;
      req_target_is_null <= is_null;
      @(posedge clock);
      while (busy) @(posedge clock);
      ledger.note_request(op, size, target, is_null);
      words_sent++;
   endtask

   // Drop start and hold off until every response is in.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_random_word();
      int                pick;
      int                room;
      logic [SIZE_W-1:0] size;
      logic [TGT_W-1:0]  target;
      logic              is_null;
      pick    = int'($urandom_range(0, 99));
      size    = SIZE_W'($urandom());
      target  = TGT_W'($urandom());
      is_null = 1'($urandom_range(0, 1));
      if (pick < 45) begin
         case ($urandom_range(0, 9))
            0:       size = SIZE_W'($urandom());
            1, 2:    size = SIZE_W'($urandom_range(0, 65535));
            default: size = SIZE_W'($urandom_range(0, 4095));
         endcase
         send_word(OP_ALLOC, size, target, is_null);
      end else if (pick < 70) begin
         void'(ledger.pick_live(target));
         send_word(OP_FREE, size, target, 1'b0);
      end else if (pick < 80) begin
         send_word(OP_FREE, size, target, 1'b0);
      end else if (pick < 86) begin
         send_word(OP_FREE, size, target, 1'b1);
      end else if (pick < 90) begin
         send_word(OP_UNDEFINED, size, target, is_null);
      end else if (pick < 93) begin
         send_word(OP_CLEAR, size, target, is_null);
      end else begin
         // land right at the edge where the tracking entry no longer fits
         room = int'(POOL_BYTES) - int'(ledger.bump_offset) - int'(ENTRY_BYTES)
                + int'($urandom_range(0, 2)) - 1;
         if (room < 0) room = int'($urandom_range(0, 2));
         send_word(OP_ALLOC, SIZE_W'(room), target, is_null);
      end
   endtask

   initial begin
      int unsigned stop_at;
      int          burst;
      int          bursts;
      bit          table_filled;
      logic [TGT_W-1:0] target;

      reset              <= 1'b1;
      start              <= 1'b0;
      req_op             <= OP_ALLOC;
      req_block_size     <= '0;
      req_target_address <= '0;
      req_target_is_null <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_word(OP_FREE, '0, 20'h12345, 1'b1);
      send_word(OP_UNDEFINED, '1, '1, 1'b1);
      send_word(OP_FREE, '0, '0, 1'b0);
      send_word(OP_FREE, '0, '1, 1'b0);
      send_word(OP_ALLOC, '0, '0, 1'b0);
      send_word(OP_ALLOC, '1, '0, 1'b0);
      send_word(OP_ALLOC, SIZE_W'(POOL_BYTES), '0, 1'b0);
      send_word(OP_ALLOC, 21'd100, '0, 1'b0);
      send_word(OP_FREE, '0, 20'd24, 1'b0);
      send_word(OP_FREE, '0, 20'd24, 1'b0);
      send_word(OP_FREE, '0, '0, 1'b0);
      send_word(OP_CLEAR, '0, '0, 1'b0);
      // whole pool granted, no room left for the tracking entry
      send_word(OP_ALLOC, SIZE_W'(POOL_BYTES), '0, 1'b0);
      send_word(OP_ALLOC, '0, '0, 1'b0);
      send_word(OP_ALLOC, 21'd1, '0, 1'b0);
      send_word(OP_FREE, '0, '0, 1'b0);
      send_word(OP_CLEAR, '1, '1, 1'b1);
      send_word(OP_ALLOC, SIZE_W'(POOL_BYTES - ENTRY_BYTES), '0, 1'b0);
      send_word(OP_ALLOC, '0, '0, 1'b0);
      send_word(OP_FREE, '0, '0, 1'b0);
      send_word(OP_CLEAR, '0, '0, 1'b0);
      send_word(OP_ALLOC, SIZE_W'(POOL_BYTES - ENTRY_BYTES - 1), '0, 1'b0);
      send_word(OP_ALLOC, 21'd1, '0, 1'b0);
      send_word(OP_CLEAR, '0, '0, 1'b0);
      drain();

      stop_at      = words_sent + RANDOM_WORDS;
      table_filled = 1'b0;
      bursts       = 0;
      while (words_sent < stop_at) begin
         quiet = ($urandom_range(0, 3) == 0);
         if (!table_filled && words_sent > stop_at - RANDOM_WORDS + 100) begin
            // fill the table past its last slot, then churn holes
            send_word(OP_CLEAR, SIZE_W'($urandom()), TGT_W'($urandom()), 1'b0);
            repeat (MAX_ENTRIES + 6)
               send_word(OP_ALLOC, SIZE_W'($urandom_range(0, 255)), TGT_W'($urandom()),
                         1'($urandom_range(0, 1)));
            repeat (12) begin
               if (ledger.pick_live(target))
                  send_word(OP_FREE, SIZE_W'($urandom()), target, 1'b0);
               send_word(OP_ALLOC, SIZE_W'($urandom_range(0, 255)), TGT_W'($urandom()),
                         1'b0);
               send_word(OP_ALLOC, SIZE_W'($urandom_range(0, 255)), TGT_W'($urandom()),
                         1'b0);
            end
            table_filled = 1'b1;
         end else begin
            burst = int'($urandom_range(5, 30));
            repeat (burst) send_random_word();
         end
         bursts++;
         if (bursts == 3 || $urandom_range(0, 4) == 0) drain();
      end

      quiet = 1'b0;
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      ledger.check_drained();
      if (ledger.errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end
endmodule
